[sv/safc_pkg.sv]
// Package: types and constants shared by the cache prefetch core.
`timescale 1ns / 1ps
package safc_pkg;

    localparam int MAX_SETS_DEF     = 64;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_BITS_DEF    = 48;
    localparam int MAX_PREFETCH_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS           = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREFETCH_COUNT = 2'd3;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [ADDR_BITS_DEF-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] mem_reads;
        logic       mem_write;
    } out_item_t;

endpackage

[sv/safc_tag_mem.sv]
// Tag store and per-set valid bits and FIFO pointer: registered read, per-way tag write, row metadata write.
`timescale 1ns / 1ps
module safc_tag_mem #(
    parameter int SETS   = 64,
    parameter int WAYS   = 8,
    parameter int TAG_W  = 48,
    parameter int SET_W  = 6,
    parameter int PTR_W  = 3
) (
    input  logic                       clk,
    input  logic [SET_W-1:0]           rd_set,
    output logic [WAYS-1:0][TAG_W-1:0] rd_tags,
    output logic [WAYS-1:0]            rd_valid,
    output logic [PTR_W-1:0]           rd_ptr,
    input  logic                       wr_en,
    input  logic [SET_W-1:0]           wr_set,
    input  logic [WAYS-1:0]            wr_way_mask,
    input  logic [TAG_W-1:0]           wr_tag,
    input  logic                       meta_we,
    input  logic [WAYS-1:0]            wr_valid,
    input  logic [PTR_W-1:0]           wr_ptr
);

    logic [WAYS-1:0][TAG_W-1:0] mem [SETS];
    logic [WAYS+PTR_W-1:0]      meta_mem [SETS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (wr_way_mask[w])
                begin
                    mem[wr_set][w] <= wr_tag;
                end
            end
        end
        if (meta_we)
        begin
            meta_mem[wr_set] <= {wr_valid, wr_ptr};
        end
        rd_tags             <= mem[rd_set];
        {rd_valid, rd_ptr}  <= meta_mem[rd_set];
    end

endmodule

[sv/set_assoc_fifo_cache_prefetch_core.sv]
// Top level: set-associative tag store with FIFO replacement and next-line prefetch.
`timescale 1ns / 1ps
// One item is one access (read or write command and a byte address). The block looks
// up the set in a tag memory with a registered read, and on a miss writes the tag
// into the way named by the set's FIFO pointer, then walks up to prefetch_count
// following blocks the same way, counting one memory read per block filled. Each block
// lookup passes a read state (memory read) and then an evaluate state (compare and
// write back); after the last lookup a done state loads the result and the block
// returns to idle. A hit ends the walk after the demand lookup. The result is held in
// an output register; the next item is taken once the walk is done, even while the
// result waits, and the following walk holds at its end until the output register is
// free. Valid bits and FIFO pointers share the tag memory's address; after reset a
// clearing pass zeroes them set by set, and the input stalls meanwhile.
// Configuration must be written only while idle; the block itself does not enforce it.
module set_assoc_fifo_cache_prefetch_core #(
    parameter int MAX_SETS     = safc_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS     = safc_pkg::MAX_WAYS_DEF,
    parameter int MAX_PREFETCH = safc_pkg::MAX_PREFETCH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  safc_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output safc_pkg::out_item_t                  out_item,
    input  logic                                 cfg_we,
    input  logic [safc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [safc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int ADDR_BITS = safc_pkg::ADDR_BITS_DEF;
    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    // largest index width usable: min(6, floor(log2 MAX_SETS))
    localparam int IDX_LIM_RAW = $clog2(MAX_SETS + 1) - 1;
    localparam int IDX_LIM = (IDX_LIM_RAW > 6) ? 6 : IDX_LIM_RAW;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W  = ADDR_BITS;
    localparam int PF_W   = $clog2(MAX_PREFETCH + 2);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    // configuration
    logic [3:0] offset_bits_reg;
    logic [2:0] index_bits_reg;
    logic [3:0] ways_reg;
    logic [3:0] prefetch_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg    <= 4'd6;
            index_bits_reg     <= 3'd0;
            ways_reg           <= 4'd1;
            prefetch_count_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                safc_pkg::REG_OFFSET_BITS:    offset_bits_reg    <= cfg_data[3:0];
                safc_pkg::REG_INDEX_BITS:     index_bits_reg     <= cfg_data[2:0];
                safc_pkg::REG_WAYS:           ways_reg           <= cfg_data[3:0];
                safc_pkg::REG_PREFETCH_COUNT: prefetch_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective settings
    logic [3:0]  eff_off;
    logic [2:0]  eff_idx;
    logic [6:0]  eff_ways;
    logic [6:0]  eff_pf;

    always_comb
    begin
        eff_off = (offset_bits_reg > 4'd12) ? 4'd12 : offset_bits_reg;
        eff_idx = (32'(index_bits_reg) > IDX_LIM) ? 3'(IDX_LIM) : index_bits_reg;
        if (ways_reg == 4'd0)
            eff_ways = 7'd1;
        else if (32'(ways_reg) > MAX_WAYS)
            eff_ways = 7'(MAX_WAYS);
        else
            eff_ways = 7'(ways_reg);
        eff_pf = (32'(prefetch_count_reg) > MAX_PREFETCH) ? 7'(MAX_PREFETCH)
                                                           : 7'(prefetch_count_reg);
    end

    // control
    logic [2:0]           state_reg, state_next;
    logic [SET_W-1:0]     clr_reg, clr_next;
    logic                 cmd_reg;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [PF_W-1:0]      pf_left_reg, pf_left_next;
    logic [3:0]           reads_reg, reads_next;
    logic                 hit_reg, hit_next;
    logic                 out_valid_reg;
    safc_pkg::out_item_t  out_item_reg;

    // address split
    logic [ADDR_BITS-1:0] blk;
    logic [SET_W-1:0]     cur_set;
    logic [TAG_W-1:0]     cur_tag;

    always_comb
    begin
        blk     = addr_reg >> eff_off;
        cur_set = SET_W'(blk & ((ADDR_BITS'(1) << eff_idx) - ADDR_BITS'(1)));
        cur_tag = TAG_W'(blk >> eff_idx);
    end

    logic [MAX_WAYS-1:0][TAG_W-1:0] rd_tags;
    logic [MAX_WAYS-1:0]            rd_valid;
    logic [WAY_W-1:0]               rd_ptr;
    logic                           mem_we;
    logic [MAX_WAYS-1:0]            mem_mask;
    logic                           found;
    logic [WAY_W-1:0]               fill_way;
    logic [WAY_W:0]                 ptr_inc;
    logic [WAY_W-1:0]               ptr_new;
    logic                           meta_we;
    logic [SET_W-1:0]               wr_set;
    logic [MAX_WAYS-1:0]            wr_valid;
    logic [WAY_W-1:0]               wr_ptr;

    always_comb
    begin
        found = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (7'(w) < eff_ways && rd_valid[w] && rd_tags[w] == cur_tag)
                found = 1'b1;
        end
        // a pointer left beyond the ways in use falls back to way 0
        fill_way = (7'(rd_ptr) >= eff_ways) ? '0 : rd_ptr;
        ptr_inc  = (WAY_W + 1)'(fill_way) + 1'b1;
        ptr_new  = (7'(ptr_inc) >= eff_ways) ? '0 : ptr_inc[WAY_W-1:0];
        mem_we   = (state_reg == ST_EVAL) && !found;
        mem_mask = MAX_WAYS'(1) << fill_way;
        // the clearing pass zeroes one set per cycle; otherwise a miss writes back the row
        meta_we  = (state_reg == ST_CLEAR) || mem_we;
        wr_set   = (state_reg == ST_CLEAR) ? clr_reg : cur_set;
        wr_valid = (state_reg == ST_CLEAR) ? '0 : (rd_valid | mem_mask);
        wr_ptr   = (state_reg == ST_CLEAR) ? '0 : ptr_new;
    end

    safc_tag_mem #(
        .SETS  (MAX_SETS),
        .WAYS  (MAX_WAYS),
        .TAG_W (TAG_W),
        .SET_W (SET_W),
        .PTR_W (WAY_W)
    ) u_tag_mem (
        .clk         (clk),
        .rd_set      (cur_set),
        .rd_tags     (rd_tags),
        .rd_valid    (rd_valid),
        .rd_ptr      (rd_ptr),
        .wr_en       (mem_we),
        .wr_set      (wr_set),
        .wr_way_mask (mem_mask),
        .wr_tag      (cur_tag),
        .meta_we     (meta_we),
        .wr_valid    (wr_valid),
        .wr_ptr      (wr_ptr)
    );

    logic in_acc;
    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_acc   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        addr_next    = addr_reg;
        pf_left_next = pf_left_reg;
        reads_next   = reads_reg;
        hit_next     = hit_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SET_W'(MAX_SETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    addr_next    = in_item.address[ADDR_BITS-1:0];
                    pf_left_next = PF_W'(eff_pf);
                    reads_next   = '0;
                    hit_next     = 1'b0;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
                state_next = ST_EVAL;
            ST_EVAL:
            begin
                // first lookup is the demand access; later ones are prefetches
                if (reads_reg == 4'd0 && !hit_reg && found &&
                    pf_left_reg == PF_W'(eff_pf))
                begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (!found)
                        reads_next = reads_reg + 4'd1;
                    if (pf_left_reg == '0)
                        state_next = ST_DONE;
                    else
                    begin
                        pf_left_next = pf_left_reg - 1'b1;
                        addr_next    = addr_reg + (ADDR_BITS'(1) << eff_off);
                        state_next   = ST_READ;
                    end
                end
            end
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            reads_reg     <= '0;
            hit_reg       <= 1'b0;
            pf_left_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            reads_reg   <= reads_next;
            hit_reg     <= hit_next;
            pf_left_reg <= pf_left_next;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (in_acc)
            cmd_reg <= in_item.cmd;
        if (state_reg == ST_DONE && out_free)
        begin
            out_item_reg.hit       <= hit_reg;
            out_item_reg.mem_reads <= reads_reg;
            out_item_reg.mem_write <= (cmd_reg == safc_pkg::CMD_WRITE);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[sim/tb_set_assoc_fifo_cache_prefetch_core.sv]
// Testbench for the set-associative FIFO cache with next-line prefetch.
`timescale 1ns / 1ps
module tb_set_assoc_fifo_cache_prefetch_core;

    // Cache model: tags, valid bits and FIFO pointers, plus a queue of the
    // access outcomes that the block still owes us.
    class cache_scoreboard;
        logic [47:0]         tags [64][8];
        bit                  vbits [64][8];
        int unsigned         fptr [64];
        int unsigned         off_r, idx_r, ways_r, pf_r;
        safc_pkg::out_item_t owed [$];
        int                  errors;

        function void clear();
            foreach (vbits[s, w]) vbits[s][w] = 0;
            foreach (fptr[s]) fptr[s] = 0;
            off_r = 6; idx_r = 0; ways_r = 1; pf_r = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [safc_pkg::CFG_IDX_W-1:0] r,
                              logic [safc_pkg::CFG_DATA_W-1:0] d);
            case (r)
                safc_pkg::REG_OFFSET_BITS:    off_r = 32'(d);
                safc_pkg::REG_INDEX_BITS:     idx_r = 32'(d[2:0]);
                safc_pkg::REG_WAYS:           ways_r = 32'(d);
                safc_pkg::REG_PREFETCH_COUNT: pf_r = 32'(d);
                default: ;
            endcase
        endfunction

        // Look a block up and allocate it on a miss; return 1 on a hit.
        function bit probe(logic [47:0] a);
            int unsigned ob, ib, nw, s, p;
            logic [47:0] blk, tg;
            ob = (off_r > 12) ? 12 : off_r;
            ib = (idx_r > 6) ? 6 : idx_r;
            nw = (ways_r == 0) ? 1 : ((ways_r > 8) ? 8 : ways_r);
            blk = a >> ob;
            s = 32'(blk & ((48'd1 << ib) - 48'd1));
            tg = blk >> ib;
            for (int w = 0; w < nw; w++)
                if (vbits[s][w] && tags[s][w] == tg) return 1;
            p = (fptr[s] >= nw) ? 0 : fptr[s];
            tags[s][p] = tg;
            vbits[s][p] = 1;
            p++;
            fptr[s] = (p >= nw) ? 0 : p;
            return 0;
        endfunction

        function void note_access(safc_pkg::in_item_t it);
            safc_pkg::out_item_t r;
            logic [47:0] pa;
            int unsigned reads, np, ob;
            ob = (off_r > 12) ? 12 : off_r;
            np = (pf_r > 8) ? 8 : pf_r;
            r.hit = probe(it.address);
            reads = 0;
            if (!r.hit)
            begin
                reads = 1;
                pa = it.address;
                for (int i = 0; i < np; i++)
                begin
                    pa = pa + (48'd1 << ob);
                    if (!probe(pa)) reads++;
                end
            end
            r.mem_reads = reads[3:0];
            r.mem_write = it.cmd;
            owed.push_back(r);
        endfunction

        function void check_result(safc_pkg::out_item_t got);
            safc_pkg::out_item_t x;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            x = owed.pop_front();
            if (got.hit !== x.hit)
            begin
                $display("%0t: hit expected %0d actual %0d", $time, x.hit, got.hit);
                errors++;
            end
            if (got.mem_reads !== x.mem_reads)
            begin
                $display("%0t: mem_reads expected %0d actual %0d", $time,
                         x.mem_reads, got.mem_reads);
                errors++;
            end
            if (got.mem_write !== x.mem_write)
            begin
                $display("%0t: mem_write expected %0d actual %0d", $time,
                         x.mem_write, got.mem_write);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    safc_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 0;
    safc_pkg::out_item_t out_item;
    logic cfg_we = 0;
    logic [safc_pkg::CFG_IDX_W-1:0] cfg_index = safc_pkg::REG_OFFSET_BITS;
    logic [safc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    cache_scoreboard sb;
    int idle_cycles = 0;
    bit hold_off = 0;        // long receiver hold-off request
    bit stall_mode = 0;      // random receiver stalls on/off
    logic [47:0] base_addr;

    always #10 clk = ~clk;

    set_assoc_fifo_cache_prefetch_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Sample at the rising edge: note accepted inputs, check accepted results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) sb.note_access(in_item);
            if (out_valid && !out_stall) sb.check_result(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
    end

    // Watchdog: a miss with full prefetch, the clearing pass after reset and the
    // long hold-off all stay below this many quiet cycles, so reaching it means
    // the block has stopped making progress.
    always @(posedge clk)
    begin
        if (idle_cycles >= 3000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: stall on its own pattern, or hold off completely on request.
    always @(negedge clk)
    begin
        if (hold_off) out_stall <= 1;
        else if (stall_mode) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= 0;
    end

    // Offer one item and hold it until it is accepted.
    task automatic send_item(logic cmd, logic [47:0] a);
        @(negedge clk);
        in_valid <= 1;
        in_item <= '{cmd: cmd, address: a};
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid after a burst and leave a gap of the given length.
    task automatic gap(int unsigned n);
        @(negedge clk);
        in_valid <= 0;
        repeat (n) @(negedge clk);
    endtask

    // Wait until every owed result has come, then give the walk time to end.
    task automatic drain();
        gap(0);
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_reg(logic [safc_pkg::CFG_IDX_W-1:0] r,
                             logic [safc_pkg::CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= r;
        cfg_data <= d;
        @(negedge clk);
        cfg_we <= 0;
        sb.set_reg(r, d);
    endtask

    task automatic setup(int unsigned ob, int unsigned ib, int unsigned nw, int unsigned pf);
        write_reg(safc_pkg::REG_OFFSET_BITS, 4'(ob));
        write_reg(safc_pkg::REG_INDEX_BITS, 4'(ib));
        write_reg(safc_pkg::REG_WAYS, 4'(nw));
        write_reg(safc_pkg::REG_PREFETCH_COUNT, 4'(pf));
    endtask

    // Address near a working base so that accesses reuse and evict blocks;
    // now and then a fully random address.
    function automatic logic [47:0] pick_addr();
        if ($urandom_range(0, 9) == 0) return 48'({$urandom(), $urandom()});
        return base_addr + 48'({$urandom_range(0, 1023), 6'(0)})
               + 48'($urandom_range(0, 4095));
    endfunction

    task automatic random_phase(int unsigned n);
        int unsigned sent, burst;
        sent = 0;
        base_addr = 48'({$urandom(), $urandom()});
        while (sent < n)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                send_item(1'($urandom_range(0, 1)), pick_addr());
                sent++;
            end
            if ($urandom_range(0, 2) == 0) gap($urandom_range(1, 20));
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Directed: reset settings, address extremes, both commands.
        send_item(safc_pkg::CMD_READ, 48'h0);
        send_item(safc_pkg::CMD_READ, 48'h0);
        send_item(safc_pkg::CMD_WRITE, 48'hFFFF_FFFF_FFFF);
        send_item(safc_pkg::CMD_WRITE, 48'hFFFF_FFFF_FFFF);
        send_item(safc_pkg::CMD_READ, 48'h0000_0000_003F);
        drain();
        // Out-of-range register values; prefetch wraps past the top address.
        setup(15, 7, 15, 15);
        send_item(safc_pkg::CMD_READ, 48'hFFFF_FFFF_F000);
        send_item(safc_pkg::CMD_WRITE, 48'h0);
        send_item(safc_pkg::CMD_READ, 48'hAAAA_5555_AAAA);
        send_item(safc_pkg::CMD_READ, 48'h5555_AAAA_5555);
        drain();
        // Zero ways and zero offset, then lower ways below the FIFO pointer.
        setup(0, 0, 0, 8);
        send_item(safc_pkg::CMD_READ, 48'h10);
        send_item(safc_pkg::CMD_READ, 48'h11);
        drain();
        setup(0, 2, 8, 0);
        for (int i = 0; i < 6; i++) send_item(safc_pkg::CMD_WRITE, 48'(48'h100 * i));
        drain();
        write_reg(safc_pkg::REG_WAYS, 2);
        send_item(safc_pkg::CMD_READ, 48'h500);
        send_item(safc_pkg::CMD_READ, 48'h0);
        drain();
        write_reg(safc_pkg::REG_WAYS, 8);   // hidden ways come back into view
        send_item(safc_pkg::CMD_READ, 48'h300);
        send_item(safc_pkg::CMD_READ, 48'h400);
        drain();

        // Random phases across settings, extremes among them.
        stall_mode = 1;
        setup(6, 3, 4, 2);  random_phase(200);
        setup(12, 6, 8, 8); random_phase(150);
        setup(4, 1, 1, 0);  random_phase(150);
        setup(2, 4, 2, 3);  random_phase(150);
        setup(0, 0, 8, 8);  random_phase(100);

        // Long receiver hold-off while the sender keeps offering.
        setup(6, 2, 3, 1);
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            random_phase(150);
        join
        stall_mode = 0;
        setup(3, 5, 5, 4); random_phase(200);

        drain();
        if (sb.errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

[set_assoc_fifo_cache_prefetch_core.f]
sv/safc_pkg.sv
sv/safc_tag_mem.sv
sv/set_assoc_fifo_cache_prefetch_core.sv
sim/tb_set_assoc_fifo_cache_prefetch_core.sv
